// ===== src/dwmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwmd_pkg
// shared types and fixed constants of the distinct window marker detector
// ----------------------------------------------------------------------------
package dwmd_pkg;

    // fixed field widths
    localparam int SYMBOL_W  = 8;
    localparam int CFG_W     = 4;
    localparam int POS_OUT_W = 16;
    localparam int LETTER_W  = 5;

    // lowercase letter range
    localparam logic [SYMBOL_W-1:0] LETTER_LOW  = 8'd97;
    localparam logic [SYMBOL_W-1:0] LETTER_HIGH = 8'd122;

    // window length after reset, and the smallest usable window
    localparam logic [CFG_W-1:0] WINDOW_RESET = 4'd4;
    localparam logic [CFG_W-1:0] WINDOW_MIN   = 4'd2;

    // one result item
    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] marker_position;
    } t_result;

endpackage

// ===== src/dwmd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwmd_core
// per-stream state: recent letters, distinct run length, letter count
// ----------------------------------------------------------------------------
module dwmd_core #(
    parameter int MAX_WINDOW    = 14,
    parameter int POSITION_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [dwmd_pkg::SYMBOL_W-1:0] i_symbol,
    input  logic                         i_end_of_stream,
    input  logic [dwmd_pkg::CFG_W-1:0]    i_window_length,
    output logic                         o_res_valid,
    output dwmd_pkg::t_result            o_res
);
    import dwmd_pkg::*;

    localparam int RUN_W   = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W   = (RUN_W > CFG_W) ? RUN_W : CFG_W;
    localparam int DEPTH   = MAX_WINDOW - 1;

    // older letters, newest at index 0, held as offsets from 'a'
    logic [LETTER_W-1:0]      r_recent [DEPTH];
    logic [RUN_W-1:0]         r_run;
    logic [RUN_W-1:0]         n_run;
    logic [POSITION_BITS-1:0] r_count;
    logic [POSITION_BITS-1:0] n_count;
    logic                     r_done;

    logic                     is_letter;
    logic                     take;
    logic                     beyond;
    logic                     marker;
    logic                     clear;
    logic [LETTER_W-1:0]      code;
    logic [SYMBOL_W-1:0]      offset;
    logic [DEPTH-1:0]         hit;
    logic [CMP_W-1:0]         win_ext;
    logic [CMP_W-1:0]         win_eff;
    logic [POS_OUT_W-1:0]     pos_out;

    assign is_letter = (i_symbol >= LETTER_LOW) && (i_symbol <= LETTER_HIGH);
    assign take      = i_step && is_letter && !r_done;
    assign clear     = i_step && i_end_of_stream;
    assign offset    = i_symbol - LETTER_LOW;
    assign code      = offset[LETTER_W-1:0];
    assign beyond    = (r_count == {POSITION_BITS{1'b1}});

    // clamp the programmed window length
    assign win_ext = CMP_W'(i_window_length);
    always_comb begin
        if (i_window_length < WINDOW_MIN) begin
            win_eff = CMP_W'(WINDOW_MIN);
        end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
            win_eff = CMP_W'(MAX_WINDOW);
        end else begin
            win_eff = win_ext;
        end
    end

    // matches inside the current distinct run only
    always_comb begin
        for (int j = 0; j < DEPTH; j++) begin
            hit[j] = (r_recent[j] == code) && (RUN_W'(j) < r_run);
        end
    end

    // new run length: distance to the nearest repeat, else one longer up to MAX_WINDOW
    always_comb begin
        if (r_run == RUN_W'(MAX_WINDOW)) begin
            n_run = r_run;
        end else begin
            n_run = r_run + RUN_W'(1);
        end
        for (int j = DEPTH - 1; j >= 0; j--) begin
            if (hit[j]) begin
                n_run = RUN_W'(j + 1);
            end
        end
    end

    assign n_count = beyond ? r_count : r_count + POSITION_BITS'(1);

    assign marker = take && !beyond
                    && (n_count >= POSITION_BITS'(win_eff))
                    && (CMP_W'(n_run) >= win_eff);

    generate
        if (POSITION_BITS >= POS_OUT_W) begin : g_pos_trunc
            assign pos_out = n_count[POS_OUT_W-1:0];
        end else begin : g_pos_ext
            assign pos_out = POS_OUT_W'(n_count);
        end
    endgenerate

    assign o_res_valid           = marker || (clear && !r_done);
    assign o_res.found           = marker;
    assign o_res.marker_position = marker ? pos_out : '0;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_recent[0] <= code;
            for (int k = 1; k < DEPTH; k++) begin
                r_recent[k] <= r_recent[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (clear) begin
            r_run   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (take) begin
            r_run   <= n_run;
            r_count <= n_count;
            if (marker) begin
                r_done <= 1'b1;
            end
        end
    end

    // a result only comes out of an item being processed
    a_res_needs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_step)
        else $error("result without an item");

    // end of stream leaves a clean state
    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear |=> (r_run == '0) && (r_count == '0) && !r_done)
        else $error("state not cleared after end of stream");

    // the distinct run never exceeds the letters counted
    a_run_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        POSITION_BITS'(r_run) <= r_count)
        else $error("run length above letter count");

    // no second marker in a stream
    a_one_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !marker)
        else $error("marker after marker");

endmodule

// ===== src/distinct_window_marker_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_window_marker_detector_unit
// finds the first full window of pairwise distinct lowercase letters
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall with i_symbol and i_end_of_stream; an
//   item is taken on a clock edge with i_valid high and o_stall low
//   output channel: o_valid / i_stall with o_found and o_marker_position;
//   an item leaves on an edge with o_valid high and i_stall low
//   config channel: i_cfg_valid / o_cfg_ready with i_cfg_data, the window
//   length; o_cfg_ready is always high, write it only while idle
//   only bytes 'a'..'z' count; a stream gives at most one result item:
//   found with the 1-based letter position, or not found at its last byte
//   path: an item is registered on acceptance; once the result register has
//   room it moves on, and its result, if any, is loaded into the output
//   register that drives o_valid
//   throughput: one item per cycle while no result waits under i_stall;
//   each item updates the distinct run length and letter count in dwmd_core
//   stall: while a result waits under i_stall the input register holds one
//   item and o_stall rises; the items behind it wait at the input
//   reset: synchronous, active low; clears stream state and sets the window
//   length to 4
// ----------------------------------------------------------------------------
module distinct_window_marker_detector_unit #(
    parameter int MAX_WINDOW    = 14,
    parameter int POSITION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [dwmd_pkg::SYMBOL_W-1:0]  i_symbol,
    input  logic                           i_end_of_stream,
    // result items
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_found,
    output logic [dwmd_pkg::POS_OUT_W-1:0] o_marker_position,
    // window length register
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dwmd_pkg::CFG_W-1:0]     i_cfg_data
);
    import dwmd_pkg::*;

    // input register
    logic                r_in_valid;
    logic [SYMBOL_W-1:0] r_in_symbol;
    logic                r_in_eos;

    // result register
    logic                r_out_valid;
    t_result             r_out;

    // configuration
    logic [CFG_W-1:0]    r_window_length;

    logic                advance;
    logic                res_valid;
    t_result             res;

    // the held item moves on once the result register has room
    assign advance     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_RESET;
        end else if (i_cfg_valid) begin
            r_window_length <= i_cfg_data;
        end
    end

    // input register: refills whenever the held item moves or is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_symbol <= i_symbol;
            r_in_eos    <= i_end_of_stream;
        end
    end

    dwmd_core #(
        .MAX_WINDOW    (MAX_WINDOW),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_symbol        (r_in_symbol),
        .i_end_of_stream (r_in_eos),
        .i_window_length (r_window_length),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // result register: loads a new result, empties when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_found           = r_out.found;
    assign o_marker_position = r_out.marker_position;

endmodule

// ===== tb/sv/tb_distinct_window_marker_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distinct_window_marker_detector_unit
// self-checking bench: a short table of hand-picked bytes, most with typed results,
// then random letter streams with planted distinct runs over several window
// settings, under random sender bursts and receiver stalls; every result item
// is compared against its expectation, typed in the table or taken from a
// cycle-free model of the marker search kept inside the bench
// ----------------------------------------------------------------------------
module tb_distinct_window_marker_detector_unit;
    import dwmd_pkg::*;

    localparam int MAX_WIN        = 14;
    localparam int POS_BITS       = 16;
    localparam int COUNT_MAX      = (1 << POS_BITS) - 1;
    localparam int SETTLE_CYCLES  = 4;    // extra wait once no result is pending
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 150;  // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000; // cycles with no handshake at all
    localparam int PHASE_ITEMS    = 135;  // counted items per window setting
    localparam int NUM_PHASES     = 8;
    localparam int HOLD_PHASE     = 3;
    localparam int MAX_REPORTS    = 20;
    localparam int OPENING_ROWS   = 22;

    // how a table row gets its expected result
    typedef enum logic [1:0] {
        ROW_PREDICT, // taken from the model below
        ROW_QUIET,   // no result item
        ROW_FOUND,   // found at the typed position
        ROW_MISS     // stream ended without a marker
    } t_row_check;

    typedef struct packed {
        logic [SYMBOL_W-1:0]  sym;
        logic                 eos;
        t_row_check           how;
        logic [POS_OUT_W-1:0] pos;
    } t_opening_row;

    // receiver stall patterns
    typedef enum logic [1:0] {
        FLOW_OPEN,
        FLOW_LIGHT,
        FLOW_HEAVY,
        FLOW_PERIODIC
    } t_flow;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [SYMBOL_W-1:0]  i_symbol = '0;
    logic                 i_end_of_stream = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_found;
    logic [POS_OUT_W-1:0] o_marker_position;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // model state of the marker search
    logic [SYMBOL_W-1:0]  letter_history [MAX_WIN];
    logic [POS_BITS-1:0]  letter_count;
    logic                 marker_seen;
    logic [CFG_W-1:0]     window_setting;

    t_result awaited_results [$];

    int  burst_left = 0;
    bit  no_gaps = 1'b0;
    bit  stall_hold_req = 1'b0;
    int  mismatches = 0;
    int  found_results = 0;
    int  missed_results = 0;
    int  streams_sent = 0;
    int  window_writes = 0;
    int  backpressure_cycles = 0;

    // hand-picked opening stream, window length at its reset value of 4
    t_opening_row opening_rows [OPENING_ROWS] = '{
        '{8'h61, 1'b0, ROW_QUIET,   16'd0}, // a
        '{8'h62, 1'b0, ROW_QUIET,   16'd0}, // b
        '{8'h00, 1'b0, ROW_QUIET,   16'd0}, // ignored bytes around the letter range
        '{8'h60, 1'b0, ROW_QUIET,   16'd0},
        '{8'h7B, 1'b0, ROW_QUIET,   16'd0},
        '{8'hFF, 1'b0, ROW_QUIET,   16'd0},
        '{8'h63, 1'b0, ROW_QUIET,   16'd0}, // c
        '{8'h7A, 1'b0, ROW_FOUND,   16'd4}, // z completes a b c z
        '{8'h79, 1'b0, ROW_QUIET,   16'd0}, // letters after the marker are dropped
        '{8'h41, 1'b1, ROW_QUIET,   16'd0}, // end after a marker: silent
        '{8'h61, 1'b1, ROW_MISS,    16'd0}, // one letter, then end
        '{8'h80, 1'b1, ROW_MISS,    16'd0}, // stream with no letters
        '{8'h61, 1'b0, ROW_QUIET,   16'd0},
        '{8'h62, 1'b0, ROW_QUIET,   16'd0},
        '{8'h63, 1'b0, ROW_QUIET,   16'd0},
        '{8'h64, 1'b1, ROW_FOUND,   16'd4}, // marker on the last byte
        '{8'h61, 1'b0, ROW_PREDICT, 16'd0}, // repeat inside the window
        '{8'h62, 1'b0, ROW_PREDICT, 16'd0},
        '{8'h61, 1'b0, ROW_PREDICT, 16'd0},
        '{8'h63, 1'b0, ROW_PREDICT, 16'd0},
        '{8'h64, 1'b0, ROW_PREDICT, 16'd0},
        '{8'h7F, 1'b1, ROW_PREDICT, 16'd0}
    };

    distinct_window_marker_detector_unit #(
        .MAX_WINDOW   (MAX_WIN),
        .POSITION_BITS(POS_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_symbol         (i_symbol),
        .i_end_of_stream  (i_end_of_stream),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_found          (o_found),
        .o_marker_position(o_marker_position),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit is_letter(input logic [SYMBOL_W-1:0] sym);
        return sym >= LETTER_LOW && sym <= LETTER_HIGH;
    endfunction

    // register values outside 2..MAX_WIN act as the nearest bound
    function automatic int clamped_window();
        if (window_setting < WINDOW_MIN)
            return WINDOW_MIN;
        if (window_setting > MAX_WIN)
            return MAX_WIN;
        return window_setting;
    endfunction

    function automatic void clear_stream_model();
        foreach (letter_history[k])
            letter_history[k] = '0;
        letter_count = '0;
        marker_seen  = 1'b0;
    endfunction

    // one input item through the marker search; at most one result item
    function automatic void predict_marker(input logic [SYMBOL_W-1:0] sym, input logic eos,
                                           output logic emits, output t_result res);
        int  w;
        bit  beyond;
        bit  distinct;
        emits = 1'b0;
        res   = '0;
        if (!marker_seen && is_letter(sym)) begin
            w      = clamped_window();
            beyond = (letter_count == COUNT_MAX);
            for (int k = MAX_WIN - 1; k > 0; k--)
                letter_history[k] = letter_history[k-1];
            letter_history[0] = sym;
            if (!beyond)
                letter_count++;
            // a saturated count never yields a marker
            if (!beyond && letter_count >= w) begin
                distinct = 1'b1;
                for (int a = 0; a < w; a++)
                    for (int b = a + 1; b < w; b++)
                        if (letter_history[a] == letter_history[b])
                            distinct = 1'b0;
                if (distinct) begin
                    marker_seen           = 1'b1;
                    emits                 = 1'b1;
                    res.found             = 1'b1;
                    res.marker_position   = letter_count;
                end
            end
        end
        if (eos) begin
            if (!emits && !marker_seen) begin
                emits = 1'b1;
                res   = '0;
            end
            clear_stream_model();
        end
    endfunction

    task automatic report_mismatch(input string line);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, line);
    endtask

    // sender: bursts of random length with random gaps in between
    task automatic offer_byte(input logic [SYMBOL_W-1:0] sym, input logic eos,
                              input t_row_check how, input logic [POS_OUT_W-1:0] pos);
        logic    emits;
        t_result res;
        int      gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid         <= 1'b1;
        i_symbol        <= sym;
        i_end_of_stream <= eos;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        predict_marker(sym, eos, emits, res);
        case (how)
            ROW_QUIET: ;
            ROW_FOUND: awaited_results.push_back('{1'b1, pos});
            ROW_MISS:  awaited_results.push_back('{1'b0, '0});
            default: begin
                if (emits)
                    awaited_results.push_back(res);
            end
        endcase
        if (eos)
            streams_sent++;
    endtask

    // stop offering, let every result out and the pipeline drain
    task automatic settle_block();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        window_setting = value;
        window_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // random filler: a letter from an alphabet of alpha letters from base, or a raw byte at noise_pct percent
    function automatic logic [SYMBOL_W-1:0] stream_filler(input int alpha, input int base,
                                                          input int noise_pct);
        if ($urandom_range(0, 99) < noise_pct)
            return SYMBOL_W'($urandom_range(0, 255));
        return LETTER_LOW + SYMBOL_W'(base + $urandom_range(0, alpha - 1));
    endfunction

    // result side: every accepted result item against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result head;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result item with none pending: found %0b pos %0d",
                                          o_found, o_marker_position));
            end else begin
                head = awaited_results.pop_front();
                if (o_found !== head.found)
                    report_mismatch($sformatf("found: expected %0b got %0b",
                                              head.found, o_found));
                if (o_marker_position !== head.marker_position)
                    report_mismatch($sformatf("marker_position: expected %0d got %0d",
                                              head.marker_position, o_marker_position));
                if (head.found)
                    found_results++;
                else
                    missed_results++;
            end
        end
        if (i_valid && o_stall === 1'b1)
            backpressure_cycles++;
    end

    // receiver: stall patterns in random spans, plus one long hold-off on request
    initial begin : receiver_flow
        t_flow mode;
        int    span;
        int    period;
        forever begin
            if (stall_hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                stall_hold_req = 1'b0;
            end else begin
                mode   = t_flow'($urandom_range(0, 3));
                span   = $urandom_range(5, 40);
                period = $urandom_range(2, 7);
                for (int k = 0; k < span; k++) begin
                    case (mode)
                        FLOW_OPEN:  i_stall <= 1'b0;
                        FLOW_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                        FLOW_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                        default:    i_stall <= ((k % period) >= period / 2);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // ends the run when no handshake of any kind happens for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)
                    || (i_cfg_valid && o_cfg_ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_W-1:0]    window_plan [NUM_PHASES];
        logic [SYMBOL_W-1:0] stream_bytes [$];
        int                  letter_pool [26];
        int                  counted;
        int                  eff;
        int                  alpha;
        int                  base;
        int                  noise_pct;
        int                  run_start;
        int                  tmp;
        int                  j;

        clear_stream_model();
        window_setting = WINDOW_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // opening table runs at the reset window length
        foreach (opening_rows[r])
            offer_byte(opening_rows[r].sym, opening_rows[r].eos, opening_rows[r].how,
                       opening_rows[r].pos);

        // both register extremes, the clamped values and some in between
        window_plan = '{4'd0, 4'd15, 4'd2, 4'd14, 4'd1, 4'd4, 4'd0, 4'd0};
        window_plan[6] = CFG_W'($urandom_range(0, 15));
        window_plan[7] = CFG_W'($urandom_range(3, 13));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_window(window_plan[ph]);
            // one phase runs with the receiver held off and the sender flat out
            if (ph == HOLD_PHASE) begin
                no_gaps        = 1'b1;
                stall_hold_req = 1'b1;
            end
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                eff       = clamped_window();
                alpha     = $urandom_range((eff > 3) ? eff - 1 : 2, 26);
                base      = $urandom_range(0, 26 - alpha);
                noise_pct = ($urandom_range(0, 9) == 0) ? 70 : 10;
                stream_bytes.delete();
                repeat ($urandom_range(0, 2 * eff))
                    stream_bytes.push_back(stream_filler(alpha, base, noise_pct));
                // most streams carry a run of distinct letters, some with one repeat
                if ($urandom_range(0, 2) != 0) begin
                    foreach (letter_pool[k])
                        letter_pool[k] = k;
                    for (int k = 25; k > 0; k--) begin
                        j              = $urandom_range(0, k);
                        tmp            = letter_pool[k];
                        letter_pool[k] = letter_pool[j];
                        letter_pool[j] = tmp;
                    end
                    run_start = stream_bytes.size();
                    for (int k = 0; k < eff; k++)
                        stream_bytes.push_back(LETTER_LOW + SYMBOL_W'(letter_pool[k]));
                    if ($urandom_range(0, 3) == 0)
                        stream_bytes[run_start + $urandom_range(1, eff - 1)] =
                            stream_bytes[run_start];
                end
                repeat ($urandom_range(0, eff))
                    stream_bytes.push_back(stream_filler(alpha, base, noise_pct));
                stream_bytes.push_back(stream_filler(alpha, base, noise_pct));
                foreach (stream_bytes[k]) begin
                    offer_byte(stream_bytes[k], k == stream_bytes.size() - 1, ROW_PREDICT, '0);
                    if (is_letter(stream_bytes[k]) || k == stream_bytes.size() - 1)
                        counted++;
                end
            end
            no_gaps = 1'b0;
        end

        settle_block();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("coverage: %0d streams, %0d window writes, %0d markers found, %0d without",
                 streams_sent, window_writes, found_results, missed_results);
        $display("coverage: input held back %0d cycles under receiver stalls",
                 backpressure_cycles);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
